[src/assert_macros.svh]
// assertion macros for the rtl file that checks its own logic (the top level)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[src/clnw_pkg.sv]
// shared types, constants and helper functions of the lcd nibble writer
package clnw_pkg;

    // width of the number field and decimal digits needed to cover it
    localparam int unsigned NUM_W       = 32;
    localparam int unsigned CONV_DIGITS = 10;

    // digits kept from a number, low end first
    localparam int unsigned MAX_DIGITS  = 10;
    localparam int unsigned KEEP_DIGITS = (MAX_DIGITS < CONV_DIGITS) ? MAX_DIGITS : CONV_DIGITS;
    localparam int unsigned POS_W       = (KEEP_DIGITS > 1) ? $clog2(KEEP_DIGITS) : 1;

    // digit thresholds reach 9 * 10^9, which needs 34 bits
    localparam int unsigned THR_W = 34;

    localparam logic [7:0] DIGIT_BASE = 8'h30;

    // cursor command base per row, row 1 at index 0
    localparam logic [3:0][7:0] ROW_BASE = {8'hD4, 8'h94, 8'hC0, 8'h80};

    typedef enum logic [1:0] {
        OP_CMD  = 2'd0,
        OP_CHAR = 2'd1,
        OP_NUM  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        SEG_IDLE,
        SEG_CURSOR,
        SEG_BODY
    } seg_t;

    typedef logic [9:0][THR_W-1:0] thr_t;

    // one request on its way through the digit pipeline
    typedef struct packed {
        logic                             curs_en;
        logic [7:0]                       curs_cmd;
        op_t                              op;
        logic [7:0]                       payload;
        logic [NUM_W-1:0]                 rem;
        logic [KEEP_DIGITS-1:0][3:0]      digits;
        logic                             lead_seen;
        logic [POS_W-1:0]                 lead_pos;
    } frame_t;

    // serializer status seen by the top level
    typedef struct packed {
        logic busy;
        logic closing;
    } ser_stat_t;

    // k * 10^pos for k = 0..9, evaluated at elaboration only
    function automatic thr_t digit_thr(input int unsigned pos);
        logic [THR_W-1:0] p10;
        thr_t             t;
        p10 = THR_W'(1);
        for (int unsigned i = 0; i < pos; i++)
        begin
            p10 = p10 * THR_W'(10);
        end
        for (int unsigned k = 0; k < 10; k++)
        begin
            t[k] = p10 * THR_W'(k);
        end
        return t;
    endfunction

endpackage

[src/clnw_req_if.sv]
// request channel: one lcd write request with its handshake
interface clnw_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic        use_position;
    logic [2:0]  row;
    logic [4:0]  column;
    logic [7:0]  payload_byte;
    logic [31:0] number_value;

    modport source (
        output valid, operation, use_position, row, column, payload_byte, number_value,
        input  ready
    );

    modport sink (
        input  valid, operation, use_position, row, column, payload_byte, number_value,
        output ready
    );
endinterface

[src/clnw_nib_if.sv]
// nibble channel: one 4-bit bus transfer with its handshake
interface clnw_nib_if;
    logic       valid;
    logic       ready;
    logic       register_select;
    logic [3:0] nibble;
    logic       last;

    modport source (
        output valid, register_select, nibble, last,
        input  ready
    );

    modport sink (
        input  valid, register_select, nibble, last,
        output ready
    );
endinterface

[src/clnw_conv_pipe.sv]
// input register, cursor command and one-digit-per-stage decimal pipeline
module clnw_conv_pipe (
    input  logic              clk,
    input  logic              rst_n,
    clnw_req_if.sink          req,
    output clnw_pkg::frame_t  frm,
    output logic              frm_valid,
    input  logic              frm_ready
);

    clnw_pkg::frame_t                       pipe_reg  [0:clnw_pkg::CONV_DIGITS];
    clnw_pkg::frame_t                       pipe_next [0:clnw_pkg::CONV_DIGITS];
    logic [clnw_pkg::CONV_DIGITS:0]         valid_reg;
    logic [clnw_pkg::CONV_DIGITS:0]         valid_next;
    logic                                   advance;
    logic                                   row_ok;
    logic                                   op_ok;

    // whole pipeline moves unless the last stage is stuck
    assign advance   = !valid_reg[clnw_pkg::CONV_DIGITS] || frm_ready;
    assign req.ready = advance;

    // entry: cursor command and raw fields, unused opcode dropped here
    always_comb
    begin
        row_ok = req.row inside {[3'd1:3'd4]};
        op_ok  = req.operation inside {clnw_pkg::OP_CMD, clnw_pkg::OP_CHAR, clnw_pkg::OP_NUM};
        pipe_next[0].curs_en   = req.use_position && row_ok;
        pipe_next[0].curs_cmd  = clnw_pkg::ROW_BASE[req.row[1:0] - 2'd1]
                                 + {3'b000, req.column} - 8'd1;
        pipe_next[0].op        = clnw_pkg::op_t'(req.operation);
        pipe_next[0].payload   = req.payload_byte;
        pipe_next[0].rem       = req.number_value;
        pipe_next[0].digits    = '0;
        pipe_next[0].lead_seen = 1'b0;
        pipe_next[0].lead_pos  = '0;
        valid_next[0]          = req.valid && op_ok;
    end

    // digit stages, most significant position first
    for (genvar s = 1; s <= clnw_pkg::CONV_DIGITS; s++)
    begin : g_stage
        localparam int unsigned   POS = clnw_pkg::CONV_DIGITS - s;
        localparam clnw_pkg::thr_t THR = clnw_pkg::digit_thr(POS);

        logic [9:1] cmp;
        logic [3:0] dig;

        always_comb
        begin
            for (int k = 1; k <= 9; k++)
            begin
                cmp[k] = {2'b00, pipe_reg[s-1].rem} >= THR[k];
            end
            dig = 4'($countones(cmp));
            pipe_next[s]     = pipe_reg[s-1];
            pipe_next[s].rem = pipe_reg[s-1].rem - THR[dig][clnw_pkg::NUM_W-1:0];
            if (POS < clnw_pkg::KEEP_DIGITS)
            begin
                pipe_next[s].digits[POS] = dig;
                if (dig != 4'd0 && !pipe_reg[s-1].lead_seen)
                begin
                    pipe_next[s].lead_seen = 1'b1;
                    pipe_next[s].lead_pos  = clnw_pkg::POS_W'(POS);
                end
            end
            valid_next[s] = valid_reg[s-1];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i <= clnw_pkg::CONV_DIGITS; i++)
            begin
                pipe_reg[i] <= pipe_next[i];
            end
        end
    end

    assign frm       = pipe_reg[clnw_pkg::CONV_DIGITS];
    assign frm_valid = valid_reg[clnw_pkg::CONV_DIGITS];

endmodule

[src/clnw_nibble_ser.sv]
// byte sequencer and nibble output register
module clnw_nibble_ser (
    input  logic                clk,
    input  logic                rst_n,
    input  clnw_pkg::frame_t    frm,
    input  logic                frm_valid,
    output logic                frm_ready,
    output clnw_pkg::ser_stat_t stat,
    clnw_nib_if.source          lcd
);

    clnw_pkg::seg_t             seg_reg, seg_next;
    clnw_pkg::frame_t           frm_reg;
    logic [clnw_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                       lo_reg, lo_next;
    logic                       ov_reg, ov_next;
    logic                       rs_reg;
    logic [3:0]                 nib_reg;
    logic                       last_reg;

    logic [7:0]                 cur_byte;
    logic                       cur_rs;
    logic                       last_byte;
    logic                       emit;
    logic                       closing;
    logic                       take;

    // current byte and handshake decisions
    always_comb
    begin
        cur_byte  = 8'h00;
        cur_rs    = 1'b0;
        last_byte = 1'b0;
        case (seg_reg)
            clnw_pkg::SEG_CURSOR:
            begin
                cur_byte = frm_reg.curs_cmd;
            end
            clnw_pkg::SEG_BODY:
            begin
                case (frm_reg.op)
                    clnw_pkg::OP_CMD:
                    begin
                        cur_byte  = frm_reg.payload;
                        last_byte = 1'b1;
                    end
                    clnw_pkg::OP_CHAR:
                    begin
                        cur_byte  = frm_reg.payload;
                        cur_rs    = 1'b1;
                        last_byte = 1'b1;
                    end
                    clnw_pkg::OP_NUM:
                    begin
                        cur_byte  = clnw_pkg::DIGIT_BASE + {4'b0000, frm_reg.digits[pos_reg]};
                        cur_rs    = 1'b1;
                        last_byte = (pos_reg == '0);
                    end
                    default:
                    begin
                        cur_byte = 8'h00;
                    end
                endcase
            end
            default:
            begin
                cur_byte = 8'h00;
            end
        endcase
        emit      = (seg_reg != clnw_pkg::SEG_IDLE) && (!ov_reg || lcd.ready);
        closing   = emit && lo_reg && last_byte;
        take      = (seg_reg == clnw_pkg::SEG_IDLE) || closing;
        frm_ready = take;
    end

    // next sequencer state
    always_comb
    begin
        seg_next = seg_reg;
        lo_next  = lo_reg;
        pos_next = pos_reg;
        if (emit)
        begin
            lo_next = !lo_reg;
            if (lo_reg)
            begin
                case (seg_reg)
                    clnw_pkg::SEG_CURSOR:
                    begin
                        seg_next = clnw_pkg::SEG_BODY;
                    end
                    clnw_pkg::SEG_BODY:
                    begin
                        if (last_byte)
                        begin
                            seg_next = clnw_pkg::SEG_IDLE;
                        end
                        else
                        begin
                            pos_next = pos_reg - clnw_pkg::POS_W'(1);
                        end
                    end
                    default:
                    begin
                        seg_next = clnw_pkg::SEG_IDLE;
                    end
                endcase
            end
        end
        // next request takes over the moment the previous one closes
        if (take && frm_valid)
        begin
            seg_next = frm.curs_en ? clnw_pkg::SEG_CURSOR : clnw_pkg::SEG_BODY;
            lo_next  = 1'b0;
            pos_next = frm.lead_pos;
        end
        ov_next = emit || (ov_reg && !lcd.ready);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg <= clnw_pkg::SEG_IDLE;
            lo_reg  <= 1'b0;
            pos_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            seg_reg <= seg_next;
            lo_reg  <= lo_next;
            pos_reg <= pos_next;
            ov_reg  <= ov_next;
        end
    end

    // request hold and output payload
    always_ff @(posedge clk)
    begin
        if (take && frm_valid)
        begin
            frm_reg <= frm;
        end
        if (emit)
        begin
            rs_reg   <= cur_rs;
            nib_reg  <= lo_reg ? cur_byte[3:0] : cur_byte[7:4];
            last_reg <= lo_reg && last_byte;
        end
    end

    assign lcd.valid           = ov_reg;
    assign lcd.register_select = rs_reg;
    assign lcd.nibble          = nib_reg;
    assign lcd.last            = last_reg;

    assign stat.busy    = (seg_reg != clnw_pkg::SEG_IDLE);
    assign stat.closing = closing;

endmodule

[src/char_lcd_nibble_writer_unit.sv]
// top level of the character lcd 4-bit bus writer
// Takes one request per cycle on req while req.ready is high (command byte,
// character byte or decimal number, with an optional cursor move) and sends it
// on lcd as 4-bit transfers, high nibble first, register_select 0 for commands
// and 1 for data, last set on the final nibble of each request. A request
// leaves as 2 nibbles per byte: the cursor byte if asked for and the row is 1
// to 4, then one byte, or one byte per decimal digit with leading zeros dropped
// (zero gives one '0'), so 2 to 22 nibbles at one per cycle while lcd.ready
// allows. The digit pipeline (input register plus ten digit stages, one per
// decimal position) holds eleven requests while the nibble sequencer works.
// Requests with opcode 3 are accepted and dropped.
`include "assert_macros.svh"

module char_lcd_nibble_writer_unit (
    input  logic       clk,
    input  logic       rst_n,
    clnw_req_if.sink   req,
    clnw_nib_if.source lcd
);

    clnw_pkg::frame_t    frm;
    logic                frm_valid;
    logic                frm_ready;
    clnw_pkg::ser_stat_t stat;

    // decimal conversion pipeline
    clnw_conv_pipe u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .frm       (frm),
        .frm_valid (frm_valid),
        .frm_ready (frm_ready)
    );

    // nibble sequencer
    clnw_nibble_ser u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .frm       (frm),
        .frm_valid (frm_valid),
        .frm_ready (frm_ready),
        .stat      (stat),
        .lcd       (lcd)
    );

    // back-pressure on req only comes from a full last stage
    `ASSERT_NOW(a_stall_cause, !req.ready, frm_valid && !frm_ready)
    // a request moves to the sequencer only when it is free or closing
    `ASSERT_NOW(a_take_free, frm_valid && frm_ready, !stat.busy || stat.closing)
    // a request taken over is worked on in the next cycle
    `ASSERT_NEXT(a_take_busy, frm_valid && frm_ready, stat.busy)

endmodule
